@@ sv/fpr_pkg.sv @@
// Package for the framed payload receiver: sizes, phase and status codes,
// and the result bundle shared by the parser and the top level. No dependencies.
package fpr_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int BYTE_W        = 8;
    localparam int PAYLOAD_W     = 64;
    localparam int CNT_W         = 4;
    localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CFG_IDX_W     = 2;

    localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'hBB;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_DATA = 4'b0010,
        PH_CHK  = 4'b0100,
        PH_END  = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADSUM = 2'd1,
        ST_BADEND = 2'd2
    } t_status;

    typedef struct packed {
        logic                 valid;
        t_status              status;
        logic [PAYLOAD_W-1:0] payload;
    } t_result;

endpackage

@@ sv/fpr_parser.sv @@
// Frame parser: phase sequencer, payload byte store and running checksum.
// Depends on fpr_pkg; produces at most one result for each accepted beat.
module fpr_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_rx_byte,
    input  logic [7:0]             i_start_marker,
    input  logic [7:0]             i_end_marker,
    output fpr_pkg::t_result       o_result
);
    import fpr_pkg::*;

    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [BYTE_W-1:0]   r_sum, n_sum;
    logic [BYTE_W-1:0]   r_store [0:PAYLOAD_BYTES-1];
    logic [PAYLOAD_W-1:0] w_pack;
    logic                w_store_we;

    always_comb begin
        w_pack = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            w_pack[BYTE_W*i +: BYTE_W] = r_store[i];
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_sum      = r_sum;
        w_store_we = 1'b0;
        o_result   = '{valid: 1'b0, status: ST_OK, payload: '0};
        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == i_start_marker) begin
                        n_phase = PH_DATA;
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
                PH_DATA: begin
                    w_store_we = 1'b1;
                    n_sum      = r_sum + i_rx_byte;
                    n_count    = r_count + 1'b1;
                    if (n_count == CNT_W'(PAYLOAD_BYTES)) begin
                        n_phase = PH_CHK;
                    end
                end
                PH_CHK: begin
                    if (i_rx_byte == r_sum) begin
                        n_phase = PH_END;
                    end else begin
                        n_phase         = PH_HUNT;
                        o_result.valid  = 1'b1;
                        o_result.status = ST_BADSUM;
                    end
                end
                PH_END: begin
                    n_phase        = PH_HUNT;
                    o_result.valid = 1'b1;
                    if (i_rx_byte == i_end_marker) begin
                        o_result.status  = ST_OK;
                        o_result.payload = w_pack;
                    end else begin
                        o_result.status = ST_BADEND;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // The store holds only bytes of the current frame, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_count[IDX_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

@@ sv/framed_payload_receiver.sv @@
// Framed payload receiver: one byte per beat in, one status/payload beat per frame out.
// The result of a frame is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one byte per cycle; a two-entry output buffer lets input continue while
// a result waits, and input stalls only when both entries are full.
// Reset (synchronous, active low): parser hunts for the start marker, markers return to
// 0xAA and 0xBB, output buffer empties. Depends on fpr_pkg and fpr_parser.
module framed_payload_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [63:0]                     o_payload
);
    import fpr_pkg::*;

    logic [BYTE_W-1:0]    r_start_marker;
    logic [BYTE_W-1:0]    r_end_marker;
    logic                 w_accept;
    t_result              w_result;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [PAYLOAD_W-1:0] r_out_payload;
    logic                 r_skid_valid;
    t_status              r_skid_status;
    logic [PAYLOAD_W-1:0] r_skid_payload;

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_payload   = r_out_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_RESET;
            r_end_marker   <= END_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fpr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_rx_byte      (i_rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_result       (w_result)
    );

    // The skid entry only fills while the output beat is held, and drains first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_result.valid;
            end
        end else if (w_result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_status  <= r_skid_status;
                r_out_payload <= r_skid_payload;
            end else begin
                r_out_status  <= w_result.status;
                r_out_payload <= w_result.payload;
            end
        end else if (w_result.valid) begin
            r_skid_status  <= w_result.status;
            r_skid_payload <= w_result.payload;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a beat while the output register is empty");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_payload == '0))
        else $error("error status carries a nonzero payload");

    a_result_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.valid |-> w_accept)
        else $error("parser produced a result without an accepted beat");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> r_skid_valid && r_out_valid)
        else $error("buffered result lost while output is stalled");

endmodule

@@ sim/framed_payload_receiver_tb.sv @@
// Self-checking testbench for framed_payload_receiver: framed byte streams with random gaps
// and output stalls, checked beat by beat against a frame parser kept in the bench.
// Depends on fpr_pkg and the framed_payload_receiver RTL.
`timescale 1ns / 1ps

module framed_payload_receiver_tb;
    import fpr_pkg::*;

    localparam int FRAME_BYTES    = (PAYLOAD_BYTES < 1) ? 1 :
                                    ((PAYLOAD_BYTES > 8) ? 8 : PAYLOAD_BYTES);
    localparam int IDLE_PCT       = 11;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET    = 400;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_CUT} t_frame_kind;

    typedef struct {
        t_status     status;
        logic [63:0] payload;
    } t_frame_outcome;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [63:0]          o_payload;

    framed_payload_receiver DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Frame parser state kept by the bench.
    logic [7:0]     start_marker_q = START_RESET;
    logic [7:0]     end_marker_q   = END_RESET;
    t_phase         parse_phase    = PH_HUNT;
    logic [3:0]     bytes_held     = '0;
    logic [7:0]     payload_bytes [8];
    logic [7:0]     byte_sum       = '0;
    t_frame_outcome outcomes_due[$];

    int mismatches   = 0;
    int rx_items     = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_request = 1'b0;
    bit steady_flow  = 1'b0;

    function automatic void predict_rx_byte(input logic [7:0] b);
        t_frame_outcome o;
        o.status  = ST_OK;
        o.payload = '0;
        case (parse_phase)
            PH_HUNT: begin
                if (b == start_marker_q) begin
                    parse_phase = PH_DATA;
                    bytes_held  = '0;
                    byte_sum    = '0;
                end
            end
            PH_DATA: begin
                payload_bytes[bytes_held[2:0]] = b;
                byte_sum   = byte_sum + b;
                bytes_held = bytes_held + 4'd1;
                if (bytes_held >= FRAME_BYTES)
                    parse_phase = PH_CHK;
            end
            PH_CHK: begin
                if (b == byte_sum) begin
                    parse_phase = PH_END;
                end else begin
                    parse_phase = PH_HUNT;
                    o.status    = ST_BADSUM;
                    outcomes_due.push_back(o);
                end
            end
            default: begin
                parse_phase = PH_HUNT;
                if (b == end_marker_q) begin
                    for (int i = 0; i < FRAME_BYTES; i++)
                        o.payload[8*i +: 8] = payload_bytes[i];
                end else begin
                    o.status = ST_BADEND;
                end
                outcomes_due.push_back(o);
            end
        endcase
    endfunction

    // Result checker: every accepted beat is matched against the oldest outcome due.
    always @(posedge i_clk) begin
        t_frame_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcomes_due.size() == 0) begin
                $error("unexpected result beat: status %0d payload %h", o_status, o_payload);
                mismatches++;
            end else begin
                want = outcomes_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_payload !== want.payload) begin
                    $error("payload: expected %h, actual %h", want.payload, o_payload);
                    mismatches++;
                end
            end
        end
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("framed_payload_receiver_tb: errors");
            $finish;
        end
    end

    // Called and returns at a falling edge.
    task automatic send_rx_byte(input logic [7:0] b);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte  = b;
        do @(posedge i_clk); while (o_in_stall);
        predict_rx_byte(b);
        rx_items++;
        @(negedge i_clk);
    endtask

    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count) begin
            do b = 8'($urandom); while (b == start_marker_q);
            send_rx_byte(b);
        end
    endtask

    task automatic send_frame(input t_frame_kind kind, input logic [63:0] data,
                              input logic [7:0] wrong);
        logic [7:0] beats[$];
        logic [7:0] sum;
        int         n;
        sum = '0;
        n   = (kind == FRAME_CUT) ? $urandom_range(0, FRAME_BYTES - 1) : FRAME_BYTES;
        beats.push_back(start_marker_q);
        for (int i = 0; i < n; i++) begin
            beats.push_back(data[8*i +: 8]);
            sum += data[8*i +: 8];
        end
        if (kind == FRAME_BAD_SUM) begin
            beats.push_back((wrong == sum) ? sum + 8'd1 : wrong);
        end else if (kind != FRAME_CUT) begin
            beats.push_back(sum);
            if (kind == FRAME_BAD_END)
                beats.push_back((wrong == end_marker_q) ? end_marker_q + 8'd1 : wrong);
            else
                beats.push_back(end_marker_q);
        end
        foreach (beats[i])
            send_rx_byte(beats[i]);
    endtask

    // Mostly random bytes, with marker values and uniform fills mixed in.
    function automatic logic [63:0] random_payload();
        logic [63:0] v;
        int          mode;
        mode = $urandom_range(0, 15);
        if (mode == 0)
            return '0;
        if (mode == 1)
            return '1;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 7))
                0:       v[8*i +: 8] = start_marker_q;
                1:       v[8*i +: 8] = end_marker_q;
                default: v[8*i +: 8] = 8'($urandom);
            endcase
        end
        return v;
    endfunction

    task automatic send_random_frames(input int count);
        t_frame_kind kind;
        int          pick;
        repeat (count) begin
            if ($urandom_range(0, 9) < 3)
                send_noise($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                kind = FRAME_GOOD;
            else if (pick < 82)
                kind = FRAME_BAD_SUM;
            else if (pick < 94)
                kind = FRAME_BAD_END;
            else
                kind = FRAME_CUT;
            send_frame(kind, random_payload(), 8'($urandom));
        end
    endtask

    // Waits until every outcome has been delivered and the parser has settled.
    task automatic drain_outcomes();
        i_in_valid = 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        drain_outcomes();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_START_MARKER)
            start_marker_q = value;
        else if (idx == CFG_END_MARKER)
            end_marker_q = value;
    endtask

    task automatic test_directed();
        // Hunting drops anything but the start marker.
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        // Good frame with both marker values and the byte extremes inside the payload.
        send_frame(FRAME_GOOD, 64'hFE55_7F80_BBAA_FF00, 8'h00);
        // The start marker as a bad checksum must not reopen a frame.
        send_frame(FRAME_BAD_SUM, '1, start_marker_q);
        send_rx_byte(end_marker_q);
        // Same for the start marker in place of the end marker.
        send_frame(FRAME_BAD_END, '0, start_marker_q);
        send_rx_byte(8'h00);
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        send_random_frames(6);
        steady_flow = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (6)
            send_frame(FRAME_GOOD, random_payload(), 8'h00);
    endtask

    task automatic test_marker_extremes();
        write_cfg_reg(CFG_START_MARKER, 8'h00);
        write_cfg_reg(CFG_END_MARKER, 8'hFF);
        send_random_frames(4);
        write_cfg_reg(CFG_START_MARKER, 8'hFF);
        write_cfg_reg(CFG_END_MARKER, 8'h00);
        send_random_frames(4);
    endtask

    task automatic test_equal_markers();
        logic [7:0] m;
        m = 8'($urandom);
        write_cfg_reg(CFG_START_MARKER, m);
        write_cfg_reg(CFG_END_MARKER, m);
        send_random_frames(5);
    endtask

    task automatic test_spare_registers();
        write_cfg_reg(CFG_SPARE_2, 8'h00);
        write_cfg_reg(CFG_SPARE_3, 8'hFF);
        write_cfg_reg(CFG_SPARE_2, 8'hFF);
        write_cfg_reg(CFG_SPARE_3, 8'h00);
        send_random_frames(4);
    endtask

    task automatic test_random_markers();
        while (rx_items < ITEM_TARGET) begin
            write_cfg_reg(CFG_START_MARKER, 8'($urandom));
            write_cfg_reg(CFG_END_MARKER, 8'($urandom));
            send_random_frames(8);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_steady_stream();
        test_backpressure();
        test_marker_extremes();
        test_equal_markers();
        test_spare_registers();
        test_random_markers();

        drain_outcomes();
        if (mismatches == 0)
            $display("framed_payload_receiver_tb: clean");
        else
            $display("framed_payload_receiver_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/fpr_pkg.sv
sv/fpr_parser.sv
sv/framed_payload_receiver.sv
sim/framed_payload_receiver_tb.sv
